[rtl/pthc_pkg.sv]
// Shared types, register codes and constants of the pressure, temperature and
// humidity compensation datapath. No dependencies.
package pthc_pkg;

  localparam int DIV_STAGES = 64;

  localparam logic [2:0] REG_TEMP_CAL    = 3'd0;
  localparam logic [2:0] REG_PRESS_CAL_A = 3'd1;
  localparam logic [2:0] REG_PRESS_CAL_B = 3'd2;
  localparam logic [2:0] REG_PRESS_CAL_C = 3'd3;
  localparam logic [2:0] REG_HUM_CAL_A   = 3'd4;
  localparam logic [2:0] REG_HUM_CAL_B   = 3'd5;

  localparam logic [31:0] HUM_MAX   = 32'd419430400;
  localparam logic [63:0] RECIP_TEN = 64'hCCCC_CCCD;

  typedef struct packed {
    logic [31:0] temperature_centi;
    logic [15:0] temperature_tenths;
    logic [16:0] humidity_q10;
    logic [9:0]  humidity_tenths;
    logic        divisor_zero;
  } side_t;

  typedef struct packed {
    logic valid;
    logic neg;
  } div_ctl_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] nq;
  } div_state_t;

  function automatic logic [31:0] sx16_32(input logic [15:0] v);
    sx16_32 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx8_32(input logic [7:0] v);
    sx8_32 = {{24{v[7]}}, v};
  endfunction

  function automatic logic [63:0] sx16_64(input logic [15:0] v);
    sx16_64 = {{48{v[15]}}, v};
  endfunction

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  function automatic div_state_t div_step(input div_state_t s, input logic [63:0] d);
    logic [64:0] shifted;
    logic [64:0] trial;
    div_state_t  r;
    shifted = {s.rem, s.nq[63]};
    trial   = shifted - {1'b0, d};
    if (!trial[64]) begin
      r.rem = trial[63:0];
      r.nq  = {s.nq[62:0], 1'b1};
    end else begin
      r.rem = shifted[63:0];
      r.nq  = {s.nq[62:0], 1'b0};
    end
    div_step = r;
  endfunction

endpackage

[rtl/pthc_div.sv]
// Pipelined unsigned 64-bit divider, one quotient bit per stage.
// Depends on pthc_pkg; carries sign and side data alongside each item.
module pthc_div import pthc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  div_ctl_t    ctl_in,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  input  side_t       side_in,
  output div_ctl_t    ctl_out,
  output logic [63:0] quotient,
  output side_t       side_out
);

  logic [DIV_STAGES-1:0] vld;
  logic [DIV_STAGES-1:0] neg;
  div_state_t            st   [DIV_STAGES];
  logic [63:0]           dv   [DIV_STAGES];
  side_t                 side [DIV_STAGES];
  div_state_t            first;

  assign first = '{rem: 64'd0, nq: dividend};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_STAGES-2:0], ctl_in.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0]   <= div_step(first, divisor);
      dv[0]   <= divisor;
      neg[0]  <= ctl_in.neg;
      side[0] <= side_in;
      for (int i = 1; i < DIV_STAGES; i++) begin
        st[i]   <= div_step(st[i-1], dv[i-1]);
        dv[i]   <= dv[i-1];
        neg[i]  <= neg[i-1];
        side[i] <= side[i-1];
      end
    end
  end

  assign ctl_out  = '{valid: vld[DIV_STAGES-1], neg: neg[DIV_STAGES-1]};
  assign quotient = st[DIV_STAGES-1].nq;
  assign side_out = side[DIV_STAGES-1];

endmodule

[rtl/pth_sensor_compensation.sv]
// Pressure, temperature and humidity compensation pipeline (top level).
// Depends on pthc_pkg and pthc_div.
//
// Usage:
//   Raw readings enter on raw_valid/raw_stall; compensated results leave on
//   result_valid/result_stall. An item moves at a clock edge where valid is
//   high and stall is low.
//   Calibration words are written through cfg_write/cfg_index/cfg_data while
//   no item is in flight; indexes above five are ignored.
// Structure: twelve stages compute temperature, humidity and the pressure
//   divisor, 64 stages produce one quotient bit each, and seven stages finish
//   the pressure value in the result register.
// Throughput: one item per cycle unless result_stall holds the pipeline;
//   every stage is registered and advances on a single pipeline enable.
// Stall: while a result waits and result_stall is high the whole pipeline
//   holds and raw_stall is raised; nothing is lost or repeated.
// Reset: clears all valid bits and the calibration registers to zero.
module pth_sensor_compensation import pthc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               raw_valid,
  output logic               raw_stall,
  input  logic [19:0]        raw_pressure,
  input  logic [19:0]        raw_temperature,
  input  logic [15:0]        raw_humidity,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] temperature_centi,
  output logic [31:0]        pressure_pascal,
  output logic [16:0]        humidity_q10,
  output logic signed [15:0] temperature_tenths,
  output logic [9:0]         humidity_tenths,
  output logic               pressure_divisor_zero,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data
);

  logic [47:0] temp_cal, press_cal_a, press_cal_b, press_cal_c;
  logic [31:0] hum_cal_a;
  logic [39:0] hum_cal_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal    <= '0;
      press_cal_a <= '0;
      press_cal_b <= '0;
      press_cal_c <= '0;
      hum_cal_a   <= '0;
      hum_cal_b   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TEMP_CAL:    temp_cal    <= cfg_data;
        REG_PRESS_CAL_A: press_cal_a <= cfg_data;
        REG_PRESS_CAL_B: press_cal_b <= cfg_data;
        REG_PRESS_CAL_C: press_cal_c <= cfg_data;
        REG_HUM_CAL_A:   hum_cal_a   <= cfg_data[31:0];
        REG_HUM_CAL_B:   hum_cal_b   <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  logic [15:0] t1, p1;
  logic [31:0] t2, t3, h1, h2, h3, h4, h5, h6;
  logic [63:0] p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = temp_cal[15:0];
  assign t2 = sx16_32(temp_cal[31:16]);
  assign t3 = sx16_32(temp_cal[47:32]);
  assign p1 = press_cal_a[15:0];
  assign p2 = sx16_64(press_cal_a[31:16]);
  assign p3 = sx16_64(press_cal_a[47:32]);
  assign p4 = sx16_64(press_cal_b[15:0]);
  assign p5 = sx16_64(press_cal_b[31:16]);
  assign p6 = sx16_64(press_cal_b[47:32]);
  assign p7 = sx16_64(press_cal_c[15:0]);
  assign p8 = sx16_64(press_cal_c[31:16]);
  assign p9 = sx16_64(press_cal_c[47:32]);
  assign h1 = {24'd0, hum_cal_a[7:0]};
  assign h2 = sx16_32(hum_cal_a[23:8]);
  assign h3 = {24'd0, hum_cal_a[31:24]};
  assign h4 = sx16_32(hum_cal_b[15:0]);
  assign h5 = sx16_32(hum_cal_b[31:16]);
  assign h6 = sx8_32(hum_cal_b[39:32]);

  logic en;
  assign en        = !result_valid || !result_stall;
  assign raw_stall = !en;

  logic [11:0] fv;
  logic [6:0]  bv;
  div_ctl_t    dctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
      bv <= '0;
    end else if (en) begin
      fv <= {fv[10:0], raw_valid};
      bv <= {bv[5:0], dctl.valid};
    end
  end
  assign result_valid = bv[6];

  logic [19:0] adcp_pipe [9];
  logic [15:0] adch_pipe [5];
  logic [31:0] tc_pipe   [7];
  logic [15:0] tt_pipe   [4];

  logic [31:0] ta, td, tm1, tdd, tv1, tm2, tfine, hv;
  logic [32:0] q1;
  logic [63:0] q1w, qsq, q1p5, q1p2, x6, x3, q2a, q2b, q2c, q1b, m9, q1c, q1e, numa, num, q1d;
  logic        dz10, dz11;
  logic [31:0] ha6, ha7, ha8, hb1, hb2, hb, hc, hv2, hv2b, hv2c, hcc, hr;
  logic        tneg6, tneg7;
  logic [31:0] tmag;
  logic [63:0] tprod;
  logic [63:0] nabs, dabs;
  logic        sneg;
  side_t       side12;

  logic [31:0] hf, hclamp;
  logic [16:0] hq;
  logic [19:0] hq10;
  logic [15:0] tq;

  assign q1w = {{31{q1[32]}}, q1};
  assign tq  = tprod[50:35];

  always_comb begin
    hf = hv2c - 32'($signed($signed(hr) >>> 4));
    if (hf[31]) begin
      hclamp = 32'd0;
    end else if (hf > HUM_MAX) begin
      hclamp = HUM_MAX;
    end else begin
      hclamp = hf;
    end
    hq   = hclamp[28:12];
    hq10 = {3'd0, hq} * 20'd10;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adcp_pipe[0] <= raw_pressure;
      adch_pipe[0] <= raw_humidity;
      for (int i = 1; i < 9; i++) adcp_pipe[i] <= adcp_pipe[i-1];
      for (int i = 1; i < 5; i++) adch_pipe[i] <= adch_pipe[i-1];
      for (int i = 1; i < 7; i++) tc_pipe[i] <= tc_pipe[i-1];
      for (int i = 1; i < 4; i++) tt_pipe[i] <= tt_pipe[i-1];

      // temperature
      td    <= ({12'd0, raw_temperature} >> 4) - {16'd0, t1};
      ta    <= ({12'd0, raw_temperature} >> 3) - {15'd0, t1, 1'b0};
      tm1   <= ta * t2;
      tdd   <= td * td;
      tv1   <= 32'($signed(tm1) >>> 11);
      tm2   <= 32'($signed(tdd) >>> 12) * t3;
      tfine <= tv1 + 32'($signed(tm2) >>> 14);
      tc_pipe[0] <= 32'($signed(tfine * 32'd5 + 32'd128) >>> 8);
      q1    <= {tfine[31], tfine} - 33'd128000;
      hv    <= tfine - 32'd76800;

      // temperature in tenths
      tneg6 <= tc_pipe[0][31];
      tmag  <= tc_pipe[0][31] ? (32'd0 - tc_pipe[0]) : tc_pipe[0];
      tneg7 <= tneg6;
      tprod <= {32'd0, tmag} * RECIP_TEN;
      tt_pipe[0] <= tneg7 ? (16'd0 - tq) : tq;

      // pressure divisor and numerator
      qsq  <= q1w * q1w;
      q1p5 <= q1w * p5;
      q1p2 <= q1w * p2;
      x6   <= qsq * p6;
      x3   <= qsq * p3;
      q2a  <= q1p5;
      q1d  <= q1p2;
      q2b  <= x6 + (q2a << 17) + (p4 << 35);
      q1b  <= 64'($signed(x3) >>> 8) + (q1d << 12);
      m9   <= (64'h8000_0000_0000 + q1b) * {48'd0, p1};
      q2c  <= q2b;
      q1c  <= 64'($signed(m9) >>> 33);
      dz10 <= (64'($signed(m9) >>> 33) == 64'd0);
      numa <= ((64'd1048576 - {44'd0, adcp_pipe[8]}) << 31) - q2c;
      num  <= numa * 64'd3125;
      q1e  <= q1c;
      dz11 <= dz10;
      nabs <= num[63] ? (64'd0 - num) : num;
      dabs <= dz11 ? 64'd1 : (q1e[63] ? (64'd0 - q1e) : q1e);
      sneg <= num[63] ^ q1e[63];

      // humidity
      ha6  <= 32'($signed(({16'd0, adch_pipe[4]} << 14) - (h4 << 20) - h5 * hv
                          + 32'd16384) >>> 15);
      hb1  <= hv * h6;
      hb2  <= hv * h3;
      ha7  <= ha6;
      hb   <= 32'($signed(hb1) >>> 10) * (32'($signed(hb2) >>> 11) + 32'd32768);
      ha8  <= ha7;
      hc   <= (32'($signed(hb) >>> 10) + 32'd2097152) * h2;
      hv2  <= ha8 * 32'($signed(hc + 32'd8192) >>> 14);
      hcc  <= 32'($signed(hv2) >>> 15) * 32'($signed(hv2) >>> 15);
      hv2b <= hv2;
      hr   <= 32'($signed(hcc) >>> 7) * h1;
      hv2c <= hv2b;

      side12.temperature_centi  <= tc_pipe[6];
      side12.temperature_tenths <= tt_pipe[3];
      side12.humidity_q10       <= hq;
      side12.humidity_tenths    <= hq10[19:10];
      side12.divisor_zero       <= dz11;
    end
  end

  div_ctl_t    dctl_in;
  logic [63:0] dquot;
  side_t       dside;

  assign dctl_in = '{valid: fv[11], neg: sneg};

  pthc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctl_in   (dctl_in),
    .dividend (nabs),
    .divisor  (dabs),
    .side_in  (side12),
    .ctl_out  (dctl),
    .quotient (dquot),
    .side_out (dside)
  );

  logic [63:0] pq, pq1, pq2, pq3, pq4, ps, ps2, m8, m8b, m8c, m8d, pt;
  logic [63:0] ll, prod, psum, pfin;
  logic [31:0] lh, hl;
  side_t       bside [6];

  assign pfin = 64'($signed(psum) >>> 8) + (p7 << 4);

  always_ff @(posedge clk) begin
    if (en) begin
      bside[0] <= dside;
      for (int i = 1; i < 6; i++) bside[i] <= bside[i-1];

      pq   <= dctl.neg ? (64'd0 - dquot) : dquot;
      ps   <= 64'($signed(pq) >>> 13);
      m8   <= p8 * pq;
      pq1  <= pq;
      pt   <= p9 * ps;
      ps2  <= ps;
      m8b  <= m8;
      pq2  <= pq1;
      ll   <= {32'd0, pt[31:0]} * {32'd0, ps2[31:0]};
      lh   <= pt[31:0] * ps2[63:32];
      hl   <= pt[63:32] * ps2[31:0];
      m8c  <= m8b;
      pq3  <= pq2;
      prod <= ll + {lh + hl, 32'd0};
      m8d  <= m8c;
      pq4  <= pq3;
      psum <= pq4 + 64'($signed(prod) >>> 25) + 64'($signed(m8d) >>> 19);

      temperature_centi     <= bside[5].temperature_centi;
      temperature_tenths    <= bside[5].temperature_tenths;
      humidity_q10          <= bside[5].humidity_q10;
      humidity_tenths       <= bside[5].humidity_tenths;
      pressure_divisor_zero <= bside[5].divisor_zero;
      pressure_pascal       <= bside[5].divisor_zero ? 32'd0
                                                     : pfin[39:8];
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    result_valid && pressure_divisor_zero |-> pressure_pascal == 32'd0)
    else $error("pressure not forced to zero on zero divisor");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> humidity_q10 <= 17'd102400)
    else $error("humidity above clamp");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> humidity_tenths <= 10'd1000)
    else $error("humidity tenths out of range");

  assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(fv) && $stable(bv))
    else $error("pipeline advanced while held");

endmodule
